// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cause implies effect in the same cycle.
`define ASSERT_IMPLY(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error(msg);

`endif

// ----- src/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Item on the input channel
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    // Item on the output channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last_of_run;
    } out_item_t;

    // Result status codes
    localparam logic [2:0] ST_DATA    = 3'd0;
    localparam logic [2:0] ST_END     = 3'd1;
    localparam logic [2:0] ST_NOQUOTE = 3'd2;
    localparam logic [2:0] ST_BADESC  = 3'd3;
    localparam logic [2:0] ST_BADHEX  = 3'd4;
    localparam logic [2:0] ST_UNTERM  = 3'd5;
    localparam logic [2:0] ST_TRUNC   = 3'd6;

    // Source characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // Control bytes produced by escapes
    localparam logic [7:0] BS_CODE = 8'h08;
    localparam logic [7:0] FF_CODE = 8'h0C;
    localparam logic [7:0] LF_CODE = 8'h0A;
    localparam logic [7:0] CR_CODE = 8'h0D;
    localparam logic [7:0] HT_CODE = 8'h09;

    // UTF-8 encoding
    localparam logic [15:0] CP_1BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] CP_2BYTE_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF8_CONT      = 8'h80;
    localparam logic [7:0]  UTF8_CONT_MASK = 8'hC0;

    localparam logic [1:0] HEX_LAST = 2'd3;

    typedef enum logic [3:0] {
        MODE_WAIT = 4'b0001,
        MODE_STR  = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_HEX  = 4'b1000
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  hex_cnt;
        logic [15:0] code_point;
    } dec_state_t;

    // Up to three results caused by one input item
    typedef struct packed {
        logic [1:0] count;
        logic [2:0] status;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } burst_t;

endpackage

// ----- src/jsu_decode.sv -----
// ----------------------------------------------------------------------------
// jsu_decode
// Combinational decode of one source byte: next state and its result burst.
// ----------------------------------------------------------------------------
module jsu_decode
    import jsu_pkg::*;
(
    input  dec_state_t st,
    input  in_item_t   item,
    output dec_state_t st_next,
    output burst_t     res
);

    logic        fail;
    logic [2:0]  fail_status;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cp_new;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = item.in_byte[3:0];
        case (item.in_byte) inside
            [8'h30:8'h39]: hex_val = item.in_byte[3:0];
            [8'h41:8'h46], [8'h61:8'h66]: hex_val = item.in_byte[3:0] + 4'd9;
            default: hex_ok = 1'b0;
        endcase
    end

    assign cp_new = {st.code_point[11:0], hex_val};

    always_comb
    begin
        st_next     = st;
        res         = '0;
        res.status  = ST_DATA;
        fail        = 1'b0;
        fail_status = ST_DATA;
        case (st.mode)
            MODE_WAIT:
            begin
                if (!item.end_of_input && item.in_byte == CH_QUOTE)
                    st_next.mode = MODE_STR;
                else
                begin
                    fail        = 1'b1;
                    fail_status = ST_NOQUOTE;
                end
            end
            MODE_STR:
            begin
                if (item.end_of_input)
                begin
                    fail        = 1'b1;
                    fail_status = ST_UNTERM;
                end
                else if (item.in_byte == CH_QUOTE)
                begin
                    fail        = 1'b1;
                    fail_status = ST_END;
                end
                else if (item.in_byte == CH_BSLASH)
                    st_next.mode = MODE_ESC;
                else
                begin
                    res.count = 2'd1;
                    res.b0    = item.in_byte;
                end
            end
            MODE_ESC:
            begin
                if (item.end_of_input)
                begin
                    fail        = 1'b1;
                    fail_status = ST_TRUNC;
                end
                else
                begin
                    st_next.mode = MODE_STR;
                    res.count    = 2'd1;
                    case (item.in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: res.b0 = item.in_byte;
                        CH_B: res.b0 = BS_CODE;
                        CH_F: res.b0 = FF_CODE;
                        CH_N: res.b0 = LF_CODE;
                        CH_R: res.b0 = CR_CODE;
                        CH_T: res.b0 = HT_CODE;
                        CH_U:
                        begin
                            st_next.mode       = MODE_HEX;
                            st_next.hex_cnt    = 2'd0;
                            st_next.code_point = '0;
                            res.count          = 2'd0;
                        end
                        default:
                        begin
                            fail        = 1'b1;
                            fail_status = ST_BADESC;
                        end
                    endcase
                end
            end
            MODE_HEX:
            begin
                if (item.end_of_input)
                begin
                    fail        = 1'b1;
                    fail_status = ST_TRUNC;
                end
                else if (!hex_ok)
                begin
                    fail        = 1'b1;
                    fail_status = ST_BADHEX;
                end
                else if (st.hex_cnt != HEX_LAST)
                begin
                    st_next.hex_cnt    = st.hex_cnt + 2'd1;
                    st_next.code_point = cp_new;
                end
                else
                begin
                    st_next.mode       = MODE_STR;
                    st_next.hex_cnt    = 2'd0;
                    st_next.code_point = '0;
                    if (cp_new < CP_1BYTE_LIMIT)
                    begin
                        res.count = 2'd1;
                        res.b0    = cp_new[7:0];
                    end
                    else if (cp_new < CP_2BYTE_LIMIT)
                    begin
                        res.count = 2'd2;
                        res.b0    = UTF8_LEAD2 | {3'b000, cp_new[10:6]};
                        res.b1    = UTF8_CONT | {2'b00, cp_new[5:0]};
                    end
                    else
                    begin
                        res.count = 2'd3;
                        res.b0    = UTF8_LEAD3 | {4'b0000, cp_new[15:12]};
                        res.b1    = UTF8_CONT | {2'b00, cp_new[11:6]};
                        res.b2    = UTF8_CONT | {2'b00, cp_new[5:0]};
                    end
                end
            end
            default:
            begin
                fail        = 1'b1;
                fail_status = ST_NOQUOTE;
            end
        endcase

        // Any error or string end: one result, back to waiting for a quote
        if (fail)
        begin
            st_next.mode       = MODE_WAIT;
            st_next.hex_cnt    = 2'd0;
            st_next.code_point = '0;
            res                = '0;
            res.count          = 2'd1;
            res.status         = fail_status;
        end
    end

endmodule

// ----- src/json_string_unescape.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape
// Decodes quoted JSON strings, one at a time, byte by byte, into bytes and status codes.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake             | Payload
// in      | in  | in_valid / in_ready   | in_data  (in_item_t)
// out     | out | out_valid / out_ready | out_data (out_item_t)
//
// Each input item sits in the input register, then decodes into a burst
// register of up to three results, which drain one per cycle while
// out_ready is high. Sustained rate is then one item per cycle; a last hex
// digit that encodes to two or three UTF-8 bytes holds the input until the
// burst drains to its last result.
// rst_n clears the valid flag, decoder state and burst count asynchronously; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module json_string_unescape
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic       in_valid_reg, in_valid_next;
    in_item_t   in_item_reg;
    dec_state_t st_reg, st_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] status_reg;
    logic [7:0] b0_reg, b1_reg, b2_reg;

    dec_state_t dec_st;
    burst_t     dec_res;
    logic       load;
    logic       out_pop;

    jsu_decode u_decode (
        .st      (st_reg),
        .item    (in_item_reg),
        .st_next (dec_st),
        .res     (dec_res)
    );

    assign out_valid = (cnt_reg != 2'd0);
    assign out_pop   = out_valid && out_ready;
    // Advance when the burst is empty or its last result leaves this cycle
    assign load      = in_valid_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready));
    assign in_ready  = !in_valid_reg || load;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (load)
            in_valid_next = 1'b0;

        st_next  = load ? dec_st : st_reg;

        cnt_next = cnt_reg;
        if (load)
            cnt_next = dec_res.count;
        else if (out_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            st_reg       <= '{mode: MODE_WAIT, hex_cnt: 2'd0, code_point: 16'd0};
            cnt_reg      <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            st_reg       <= st_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
        if (load)
        begin
            status_reg <= dec_res.status;
            b0_reg     <= dec_res.b0;
            b1_reg     <= dec_res.b1;
            b2_reg     <= dec_res.b2;
        end
        else if (out_pop)
        begin
            // Shift the next byte of the burst to the front
            b0_reg <= b1_reg;
            b1_reg <= b2_reg;
        end
    end

    assign out_data.out_byte    = b0_reg;
    assign out_data.status      = status_reg;
    assign out_data.last_of_run = (cnt_reg == 2'd1);

    `ASSERT_CLK(a_mode_onehot, $onehot(st_reg.mode), "mode register not one-hot")
    `ASSERT_IMPLY(a_wait_clear, st_reg.mode == MODE_WAIT,
        st_reg.hex_cnt == 2'd0 && st_reg.code_point == 16'd0, "hex state not cleared")
    `ASSERT_IMPLY(a_multi_is_data, cnt_reg > 2'd1, status_reg == ST_DATA,
        "multi-result burst without data status")
    `ASSERT_IMPLY(a_cont_byte, cnt_reg > 2'd1, (b1_reg & UTF8_CONT_MASK) == UTF8_CONT,
        "pending byte is not a UTF-8 continuation")

endmodule
